// ===== hw/rtl/bmat_pkg.sv =====
// Shared types and constants of the bank-mapped address translator.
// Holds command codes, sequencer states and stream field positions.
// No dependencies.
package bmat_pkg;

  localparam int ADDR_W      = 16;
  localparam int LEN_W       = 17;
  localparam int BASE_W      = 20;
  localparam int BANKF_W     = 5;
  localparam int TIDX_W      = 4;
  localparam int CMD_W       = 4;
  localparam int MAX_RESULTS = 33;
  localparam int SEG_W       = 6;

  localparam logic [ADDR_W-1:0] ROM_START   = 16'hD000;
  localparam logic [LEN_W-1:0]  SPACE_BYTES = 17'h10000;

  // input tdata layout, lowest bit up
  localparam int IN_ADDR_LSB  = 0;
  localparam int IN_END_LSB   = 16;
  localparam int IN_LEN_LSB   = 32;
  localparam int IN_BANK_LSB  = 49;
  localparam int IN_RBASE_LSB = 54;
  localparam int IN_WBASE_LSB = 74;
  localparam int IN_TDATA_W   = 96;
  localparam int IN_TUSER_W   = 4;

  // result tdata layout, lowest bit up
  localparam int OUT_USED_W  = BASE_W + LEN_W + 1 + TIDX_W;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_BANK = 4'd0,
    CMD_ADD_RTRAP = 4'd1,
    CMD_ADD_WTRAP = 4'd2,
    CMD_CLR_RTRAP = 4'd3,
    CMD_CLR_WTRAP = 4'd4,
    CMD_RD_ACC    = 4'd5,
    CMD_WR_ACC    = 4'd6,
    CMD_RD_RUN    = 4'd7,
    CMD_WR_RUN    = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SGL_RD,
    ST_SGL_WAIT,
    ST_SGL_SCAN,
    ST_RUN_CALC,
    ST_RUN_FETCH,
    ST_RUN_STEP,
    ST_FIN
  } state_t;

endpackage

// ===== hw/rtl/bank_mapped_address_translator_unit.sv =====
// Top level of the bank-mapped address translator: map memories, trap tables,
// a small sequencer and one shared translate/compare step. Uses bmat_pkg.
//
// Usage:
//  - Input channel in_*: one command item per handshake; in_tuser carries the
//    command code, in_tdata the operands. Result channel out_*: one item per
//    single access, one item per physical segment of a run; out_tlast marks the
//    final item of a command. Set-bank, add-trap and clear commands give none.
//  - Sequence: set-bank, add and clear complete on accept. A single access reads
//    the map, waits, then compares trap slots (one slot per cycle, at most the
//    current trap count) before its item enters the output register. A run takes
//    each bank-sized piece through the calc, fetch and step states, then hands
//    over the final segment; the piece loop is set by the single read port of the
//    map memory and the shared piece/merge step.
//  - The block takes one command at a time; in_tready is high once the
//    previous command has handed its last item to the output register.
//  - Reset restores the power-on map (per-bank valid bits fall back to the
//    built-in map values) and empties both trap tables. No clearing pass.
//  - When the receiver stalls, the output register holds its item and the
//    sequencer waits at the next segment hand-over; nothing is dropped.
//  - BANK_BYTES and BANK_COUNT must be powers of two.
module bank_mapped_address_translator_unit #(
  parameter int BANK_BYTES = 2048,
  parameter int BANK_COUNT = 32,
  parameter int TRAP_SLOTS = 16,
  parameter int MAIN_BASE  = 0,
  parameter int SINK_BASE  = 65536,
  parameter int PHYS_BITS  = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // addr[15:0], end_addr[31:16], run_length[48:32], bank[53:49],
  // read_base[73:54], write_base[93:74], zero[95:94]
  input  logic [bmat_pkg::IN_TDATA_W-1:0] in_tdata,
  // cmd[3:0]
  input  logic [bmat_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // phys_offset[19:0], seg_length[36:20], trap_hit[37], trap_index[41:38],
  // zero[47:42]
  output logic [bmat_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import bmat_pkg::*;

  localparam int OFF_W  = $clog2(BANK_BYTES);
  localparam int BIDX_W = $clog2(BANK_COUNT);
  localparam int IDX_W  = (TRAP_SLOTS > 1) ? $clog2(TRAP_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TRAP_SLOTS + 1);
  localparam int PB     = PHYS_BITS;
  localparam int OCH_W  = OFF_W + 1;

  // ---------------------------------------------------------------- state
  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]   a_r, a_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    chunk_r, chunk_nxt;
  logic [OCH_W-1:0]    offch_r, offch_nxt;
  logic [PB-1:0]       cur_start_r, cur_start_nxt;
  logic [LEN_W-1:0]    cur_len_r, cur_len_nxt;
  logic [PB-1:0]       cur_end_r, cur_end_nxt;
  logic [SEG_W-1:0]    nseg_r, nseg_nxt;
  logic                hit_r, hit_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]    wr_cnt_r, wr_cnt_nxt;
  logic [BANK_COUNT-1:0] map_vld_r, map_vld_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [BASE_W-1:0]   out_phys_r, out_phys_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [TIDX_W-1:0]   out_tidx_r, out_tidx_nxt;
  logic                out_last_r, out_last_nxt;

  // ---------------------------------------------------------------- memories
  logic [PB-1:0]       rd_map_mem [BANK_COUNT];
  logic [PB-1:0]       wr_map_mem [BANK_COUNT];
  logic [PB-1:0]       map_rd_q, map_wr_q;
  logic                map_vld_q;
  logic [BIDX_W-1:0]   map_idx_q;
  logic [PB-1:0]       map_val_r;
  logic                map_we;
  logic [BIDX_W-1:0]   map_waddr;
  logic [BIDX_W-1:0]   map_raddr;

  logic [2*ADDR_W-1:0] rtrap_mem [TRAP_SLOTS];
  logic [2*ADDR_W-1:0] wtrap_mem [TRAP_SLOTS];
  logic [2*ADDR_W-1:0] trap_q;
  logic                rtrap_we, wtrap_we;
  logic [IDX_W-1:0]    trap_raddr;

  // ---------------------------------------------------------------- input decode
  logic                in_acc;
  cmd_t                in_cmd;
  logic [ADDR_W-1:0]   in_addr, in_end;
  logic [LEN_W-1:0]    in_len, in_len_sat;
  logic [BANKF_W-1:0]  in_bank;
  logic [BASE_W-1:0]   in_rbase, in_wbase;
  logic                bank_ok;

  assign in_cmd     = cmd_t'(in_tuser[CMD_W-1:0]);
  assign in_addr    = in_tdata[IN_ADDR_LSB +: ADDR_W];
  assign in_end     = in_tdata[IN_END_LSB +: ADDR_W];
  assign in_len     = in_tdata[IN_LEN_LSB +: LEN_W];
  assign in_bank    = in_tdata[IN_BANK_LSB +: BANKF_W];
  assign in_rbase   = in_tdata[IN_RBASE_LSB +: BASE_W];
  assign in_wbase   = in_tdata[IN_WBASE_LSB +: BASE_W];
  assign in_len_sat = (in_len > SPACE_BYTES) ? SPACE_BYTES : in_len;
  assign bank_ok    = 32'(in_bank) < BANK_COUNT;
  assign in_acc     = in_tvalid && in_tready;

  // ---------------------------------------------------------------- decisions
  logic                side_wr;
  logic [CNT_W-1:0]    cnt_sel;
  logic [OFF_W-1:0]    off;
  logic [LEN_W-1:0]    c_bank, c_top, c_min;
  logic [PB-1:0]       phys;
  logic [PB-1:0]       map_sel, map_dflt;
  logic [32:0]         bank_start;
  logic [PB-1:0]       dflt_main;
  logic                merge, seg_cap, step_go, step_emit, last_piece;
  logic                out_free;
  logic                slot_live, slot_match, scan_done;

  always_comb begin
    side_wr    = (cmd_r == CMD_WR_ACC) || (cmd_r == CMD_WR_RUN);
    cnt_sel    = side_wr ? wr_cnt_r : rd_cnt_r;
    off        = a_r[OFF_W-1:0];
    // piece length: rest of bank, rest of 64 KB space, rest of run
    c_bank     = LEN_W'(BANK_BYTES) - LEN_W'(off);
    c_top      = SPACE_BYTES - LEN_W'(a_r);
    c_min      = (c_bank < c_top) ? c_bank : c_top;
    c_min      = (c_min < len_r) ? c_min : len_r;
    // power-on map value for the bank just read
    bank_start = 33'(map_idx_q) << OFF_W;
    dflt_main  = PB'(33'(MAIN_BASE) + bank_start);
    if (side_wr && (bank_start >= 33'(ROM_START))) begin
      map_dflt = PB'(SINK_BASE);
    end else begin
      map_dflt = dflt_main;
    end
    map_sel    = map_vld_q ? (side_wr ? map_wr_q : map_rd_q) : map_dflt;
    phys       = map_val_r + PB'(off);
    out_free   = !out_valid_r || out_tready;
    merge      = (nseg_r != '0) && (cur_end_r == phys);
    seg_cap    = !merge && (nseg_r == SEG_W'(MAX_RESULTS));
    step_emit  = !merge && (nseg_r != '0) && !seg_cap;
    step_go    = !seg_cap && (!step_emit || out_free);
    last_piece = (len_r == chunk_r);
    slot_live  = idx_r < cnt_sel;
    slot_match = slot_live && (trap_q[2*ADDR_W-1:ADDR_W] <= a_r) &&
                 (a_r <= trap_q[ADDR_W-1:0]);
    scan_done  = !slot_live || slot_match;
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_RD_ACC, CMD_WR_ACC: state_nxt = ST_SGL_RD;
            CMD_RD_RUN, CMD_WR_RUN: begin
              state_nxt = (in_len_sat != '0) ? ST_RUN_CALC : ST_IDLE;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SGL_RD:    state_nxt = ST_SGL_WAIT;
      ST_SGL_WAIT:  state_nxt = ST_SGL_SCAN;
      ST_SGL_SCAN:  state_nxt = scan_done ? ST_FIN : ST_SGL_SCAN;
      ST_RUN_CALC:  state_nxt = ST_RUN_FETCH;
      ST_RUN_FETCH: state_nxt = ST_RUN_STEP;
      ST_RUN_STEP: begin
        if (seg_cap) begin
          state_nxt = ST_FIN;
        end else if (step_go) begin
          state_nxt = last_piece ? ST_FIN : ST_RUN_CALC;
        end
      end
      ST_FIN:       state_nxt = out_free ? ST_IDLE : ST_FIN;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath and outputs
  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    cmd_nxt       = cmd_r;
    a_nxt         = a_r;
    len_nxt       = len_r;
    chunk_nxt     = chunk_r;
    offch_nxt     = offch_r;
    cur_start_nxt = cur_start_r;
    cur_len_nxt   = cur_len_r;
    cur_end_nxt   = cur_end_r;
    nseg_nxt      = nseg_r;
    hit_nxt       = hit_r;
    idx_nxt       = idx_r;
    rd_cnt_nxt    = rd_cnt_r;
    wr_cnt_nxt    = wr_cnt_r;
    map_vld_nxt   = map_vld_r;
    map_we        = 1'b0;
    map_waddr     = BIDX_W'(in_bank);
    rtrap_we      = 1'b0;
    wtrap_we      = 1'b0;
    trap_raddr    = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_phys_nxt  = out_phys_r;
    out_len_nxt   = out_len_r;
    out_hit_nxt   = out_hit_r;
    out_tidx_nxt  = out_tidx_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_cmd;
          a_nxt   = in_addr;
          len_nxt = in_len_sat;
          nseg_nxt = '0;
          hit_nxt  = 1'b0;
          idx_nxt  = '0;
          case (in_cmd)
            CMD_SET_BANK: begin
              if (bank_ok) begin
                map_we                 = 1'b1;
                map_vld_nxt[map_waddr] = 1'b1;
              end
            end
            CMD_ADD_RTRAP: begin
              if (rd_cnt_r < CNT_W'(TRAP_SLOTS)) begin
                rtrap_we   = 1'b1;
                rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
              end
            end
            CMD_ADD_WTRAP: begin
              if (wr_cnt_r < CNT_W'(TRAP_SLOTS)) begin
                wtrap_we   = 1'b1;
                wr_cnt_nxt = wr_cnt_r + CNT_W'(1);
              end
            end
            CMD_CLR_RTRAP: rd_cnt_nxt = '0;
            CMD_CLR_WTRAP: wr_cnt_nxt = '0;
            default: ;
          endcase
        end
      end
      ST_SGL_WAIT: trap_raddr = '0;
      ST_SGL_SCAN: begin
        // compare one trap slot per cycle, prefetch the next one
        trap_raddr = IDX_W'(idx_r + CNT_W'(1));
        if (scan_done) begin
          cur_start_nxt = phys;
          cur_len_nxt   = LEN_W'(1);
          hit_nxt       = slot_match;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_RUN_CALC: begin
        chunk_nxt = c_min;
        offch_nxt = OCH_W'(off) + OCH_W'(c_min);
      end
      ST_RUN_STEP: begin
        if (step_go) begin
          a_nxt   = a_r + chunk_r[ADDR_W-1:0];
          len_nxt = len_r - chunk_r;
          if (merge) begin
            // physically contiguous: grow the open segment
            cur_len_nxt = cur_len_r + chunk_r;
            cur_end_nxt = cur_end_r + PB'(chunk_r);
          end else begin
            cur_start_nxt = phys;
            cur_len_nxt   = chunk_r;
            cur_end_nxt   = map_val_r + PB'(offch_r);
            nseg_nxt      = nseg_r + SEG_W'(1);
          end
          if (step_emit) begin
            // hand over the segment just closed
            out_valid_nxt = 1'b1;
            out_phys_nxt  = BASE_W'(cur_start_r);
            out_len_nxt   = cur_len_r;
            out_hit_nxt   = 1'b0;
            out_tidx_nxt  = '0;
            out_last_nxt  = 1'b0;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_phys_nxt  = BASE_W'(cur_start_r);
          out_len_nxt   = cur_len_r;
          out_hit_nxt   = hit_r;
          out_tidx_nxt  = hit_r ? TIDX_W'(idx_r) : '0;
          out_last_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign map_raddr  = BIDX_W'(a_r >> OFF_W);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_tidx_r, out_hit_r,
                       out_len_r, out_phys_r};

  // ---------------------------------------------------------------- map memories
  always_ff @(posedge clk) begin
    if (map_we) begin
      rd_map_mem[map_waddr] <= PB'(in_rbase);
      wr_map_mem[map_waddr] <= PB'(in_wbase);
    end
    map_rd_q  <= rd_map_mem[map_raddr];
    map_wr_q  <= wr_map_mem[map_raddr];
    map_vld_q <= map_vld_r[map_raddr];
    map_idx_q <= map_raddr;
    map_val_r <= map_sel;
  end

  // ---------------------------------------------------------------- trap tables
  always_ff @(posedge clk) begin
    if (rtrap_we) begin
      rtrap_mem[rd_cnt_r[IDX_W-1:0]] <= {in_addr, in_end};
    end
    if (wtrap_we) begin
      wtrap_mem[wr_cnt_r[IDX_W-1:0]] <= {in_addr, in_end};
    end
    trap_q <= side_wr ? wtrap_mem[trap_raddr] : rtrap_mem[trap_raddr];
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      wr_cnt_r    <= '0;
      map_vld_r   <= '0;
      out_valid_r <= 1'b0;
      nseg_r      <= '0;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      cmd_r       <= CMD_SET_BANK;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      wr_cnt_r    <= wr_cnt_nxt;
      map_vld_r   <= map_vld_nxt;
      out_valid_r <= out_valid_nxt;
      nseg_r      <= nseg_nxt;
      idx_r       <= idx_nxt;
      hit_r       <= hit_nxt;
      cmd_r       <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    len_r       <= len_nxt;
    chunk_r     <= chunk_nxt;
    offch_r     <= offch_nxt;
    cur_start_r <= cur_start_nxt;
    cur_len_r   <= cur_len_nxt;
    cur_end_r   <= cur_end_nxt;
    out_phys_r  <= out_phys_nxt;
    out_len_r   <= out_len_nxt;
    out_hit_r   <= out_hit_nxt;
    out_tidx_r  <= out_tidx_nxt;
    out_last_r  <= out_last_nxt;
  end

  // ---------------------------------------------------------------- assertions
  a_trap_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_cnt_r <= CNT_W'(TRAP_SLOTS)) && (wr_cnt_r <= CNT_W'(TRAP_SLOTS)))
    else $error("trap count beyond table capacity");

  a_seg_max: assert property (@(posedge clk) disable iff (!rst_n)
    nseg_r <= SEG_W'(MAX_RESULTS))
    else $error("segment count beyond result limit");

  a_run_len_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN_CALC) |-> (len_r != '0))
    else $error("run piece started with no bytes left");

  a_piece_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN_STEP) |-> ((chunk_r != '0) && (chunk_r <= len_r)))
    else $error("run piece empty or longer than the remaining run");

endmodule
